FILE: rtl/cursor_list_engine_defines.svh
`ifndef CURSOR_LIST_ENGINE_DEFINES_SVH
`define CURSOR_LIST_ENGINE_DEFINES_SVH

// assertion helpers, sampled on clock and switched off while reset is high

// same-cycle implication
`define CLE_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("cursor list engine: check failed");

// next-cycle implication
`define CLE_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("cursor list engine: check failed");

`endif

FILE: rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the cursor list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cle_pkg;

   localparam int DEFAULT_CAPACITY = 256;

   localparam int ACTION_W = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 9;
   localparam int POS_W    = 9;

   typedef enum logic [ACTION_W-1:0] {
      ACT_QUERY      = 4'd0,
      ACT_MOVE_FRONT = 4'd1,
      ACT_MOVE_BACK  = 4'd2,
      ACT_PREV       = 4'd3,
      ACT_NEXT       = 4'd4,
      ACT_PREPEND    = 4'd5,
      ACT_APPEND     = 4'd6,
      ACT_INS_BEFORE = 4'd7,
      ACT_INS_AFTER  = 4'd8,
      ACT_DEL_FRONT  = 4'd9,
      ACT_DEL_BACK   = 4'd10,
      ACT_DEL_CURSOR = 4'd11,
      ACT_SET        = 4'd12,
      ACT_CLEAR      = 4'd13
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NO_CURSOR = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LINK_A,
      S_LINK_B,
      S_EXEC,
      S_FINISH,
      S_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic link_a;
      logic link_b;
      logic exec;
      logic finish;
      logic load_rsp;
   } cmd_type;

endpackage

FILE: rtl/cursor_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_list_engine
// Doubly linked list of signed 32-bit values with a cursor, in a node pool.
// ----------------------------------------------------------------------------
// Usage:
//   req_action/req_value enter on the req_ channel (valid/stall); each item
//   produces exactly one result on the rsp_ channel describing the list after
//   the action: status, length, cursor index (-1 when undefined) and the
//   front, back and cursor values.
//   An item goes from acceptance through the link-read states S_LINK_A and
//   S_LINK_B, the update state S_EXEC, S_FINISH for the second link write and
//   value fetch, and S_RESP, which loads the result register. The pool link
//   memories, with one read and one write port each, set this sequence.
//   A new item is taken only after the last one has loaded its result.
//   req_stall is high while an item is in flight. A result held by rsp_stall
//   sits in the output register; the next item may already be accepted and
//   waits only for its own result slot.
//   Reset empties the list, frees the whole pool and clears rsp_valid; the
//   pool memories need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cursor_list_engine_defines.svh"

module cursor_list_engine #(
   parameter int CAPACITY = cle_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cle_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [cle_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cle_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cle_pkg::LENGTH_W-1:0]        rsp_list_length,
   output logic signed [cle_pkg::POS_W-1:0]    rsp_cursor_position,
   output logic signed [cle_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic signed [cle_pkg::VALUE_W-1:0]  rsp_back_value,
   output logic signed [cle_pkg::VALUE_W-1:0]  rsp_cursor_value
);

   cle_pkg::cmd_type cmd;

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cle_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_action          (req_action),
      .req_value           (req_value),
      .rsp_status          (rsp_status),
      .rsp_list_length     (rsp_list_length),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_front_value     (rsp_front_value),
      .rsp_back_value      (rsp_back_value),
      .rsp_cursor_value    (rsp_cursor_value)
   );

   // only one item in flight
   `CLE_ASSERT_NEXT(a_single_item, cmd.accept, !cmd.accept)
   // the second write round always follows the update
   `CLE_ASSERT_NEXT(a_exec_then_finish, cmd.exec, cmd.finish)
   // a waiting result is never overwritten
   `CLE_ASSERT_IMPLY(a_no_overwrite, cmd.load_rsp, !rsp_valid || !rsp_stall)

endmodule

FILE: rtl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer of the cursor list engine: steps one item through link reads,
// update, second link write and value fetch, then hands over the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cle_pkg::cmd_type cmd
);

   cle_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cle_pkg::S_IDLE: begin
            if (req_valid) state_in = cle_pkg::S_LINK_A;
         end
         cle_pkg::S_LINK_A: state_in = cle_pkg::S_LINK_B;
         cle_pkg::S_LINK_B: state_in = cle_pkg::S_EXEC;
         cle_pkg::S_EXEC:   state_in = cle_pkg::S_FINISH;
         cle_pkg::S_FINISH: state_in = cle_pkg::S_RESP;
         cle_pkg::S_RESP: begin
            if (rsp_free) state_in = cle_pkg::S_IDLE;
         end
         default: state_in = cle_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         cle_pkg::S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         cle_pkg::S_LINK_A: cmd.link_a = 1'b1;
         cle_pkg::S_LINK_B: cmd.link_b = 1'b1;
         cle_pkg::S_EXEC:   cmd.exec   = 1'b1;
         cle_pkg::S_FINISH: cmd.finish = 1'b1;
         cle_pkg::S_RESP:   cmd.load_rsp = rsp_free;
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cle_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Node pool memories, list pointers, free list and the result register of
// the cursor list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_datapath #(
   parameter int CAPACITY = cle_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cle_pkg::cmd_type                    cmd,
   input  logic [cle_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [cle_pkg::VALUE_W-1:0]  req_value,
   output logic [cle_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cle_pkg::LENGTH_W-1:0]        rsp_list_length,
   output logic signed [cle_pkg::POS_W-1:0]    rsp_cursor_position,
   output logic signed [cle_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic signed [cle_pkg::VALUE_W-1:0]  rsp_back_value,
   output logic signed [cle_pkg::VALUE_W-1:0]  rsp_cursor_value
);

   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int VW = cle_pkg::VALUE_W;
   localparam logic [IW-1:0] NIL = IW'(CAPACITY);

   // pool memories, three copies of the values for the three result reads
   logic signed [VW-1:0] data0_mem [CAPACITY];
   logic signed [VW-1:0] data1_mem [CAPACITY];
   logic signed [VW-1:0] data2_mem [CAPACITY];
   logic [IW-1:0]        next_mem  [CAPACITY];
   logic [IW-1:0]        prev_mem  [CAPACITY];

   // item registers
   logic [cle_pkg::ACTION_W-1:0] act_ff;
   logic signed [VW-1:0]         val_ff;
   cle_pkg::status_type          status_ff, status_in;
   logic [IW-1:0]                node_ff;
   logic                         from_free_ff;

   // list state
   logic [IW-1:0] front_ff, front_in, back_ff, back_in, cur_ff, cur_in;
   logic [IW-1:0] count_ff, count_in, cidx_ff, cidx_in;
   logic [IW-1:0] free_ff, free_in, fresh_ff, fresh_in;
   logic          cvalid_ff, cvalid_in;

   // link and value read data
   logic [IW-1:0]        nrd_ff, prd_ff, nfree_ff;
   logic signed [VW-1:0] fdat_ff, bdat_ff, cdat_ff;

   // second round of link writes
   logic          w2n_en_ff, w2p_en_ff;
   logic [IW-1:0] w2n_addr_ff, w2n_data_ff, w2p_addr_ff, w2p_data_ff;

   // writes of the update cycle
   logic          e_dw_en, e_nw_en, e_pw_en, e_n2_en, e_p2_en;
   logic [IW-1:0] e_dw_addr, e_nw_addr, e_nw_data, e_pw_addr, e_pw_data;
   logic [IW-1:0] e_n2_addr, e_n2_data, e_p2_addr, e_p2_data;

   logic          nw_en, pw_en;
   logic [IW-1:0] nw_addr, nw_data, pw_addr, pw_data;
   logic [IW-1:0] prev_addr, next_addr, cnt_m1;
   logic          empty, last, full, needs_cursor, needs_node;
   logic [cle_pkg::ACTION_W-1:0] eff_act;

   assign empty  = (count_ff == '0);
   assign cnt_m1 = count_ff - IW'(1);
   assign last   = (cidx_ff == cnt_m1);
   assign full   = (free_ff == NIL) && (fresh_ff == NIL);

   // ---------------------------------------------------------------- accept
   assign needs_cursor = (req_action == cle_pkg::ACT_INS_BEFORE) ||
                         (req_action == cle_pkg::ACT_INS_AFTER) ||
                         (req_action == cle_pkg::ACT_DEL_CURSOR) ||
                         (req_action == cle_pkg::ACT_SET);
   assign needs_node   = (req_action == cle_pkg::ACT_PREPEND) ||
                         (req_action == cle_pkg::ACT_APPEND) ||
                         (req_action == cle_pkg::ACT_INS_BEFORE) ||
                         (req_action == cle_pkg::ACT_INS_AFTER);

   always_comb begin
      if ((needs_cursor || req_action == cle_pkg::ACT_DEL_FRONT ||
           req_action == cle_pkg::ACT_DEL_BACK) && empty)
         status_in = cle_pkg::ST_EMPTY;
      else if (needs_cursor && !cvalid_ff)
         status_in = cle_pkg::ST_NO_CURSOR;
      else if (needs_node && full)
         status_in = cle_pkg::ST_FULL;
      else
         status_in = cle_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff       <= req_action;
         val_ff       <= req_value;
         status_ff    <= status_in;
         node_ff      <= (free_ff != NIL) ? free_ff : fresh_ff;
         from_free_ff <= (free_ff != NIL);
      end
   end

   // ------------------------------------------------------------ link reads
   assign prev_addr = (act_ff == cle_pkg::ACT_DEL_BACK) ? back_ff : cur_ff;
   assign next_addr = (act_ff == cle_pkg::ACT_DEL_FRONT) ? front_ff : cur_ff;

   always_ff @(posedge clock) begin
      if (cmd.link_a) begin
         nrd_ff <= next_mem[free_ff[AW-1:0]];
         prd_ff <= prev_mem[prev_addr[AW-1:0]];
      end
      if (cmd.link_b) begin
         nfree_ff <= nrd_ff;
         nrd_ff   <= next_mem[next_addr[AW-1:0]];
      end
   end

   // ---------------------------------------------------------------- update
   always_comb begin
      eff_act = act_ff;
      if (act_ff == cle_pkg::ACT_INS_BEFORE && cidx_ff == '0)
         eff_act = cle_pkg::ACT_PREPEND;
      else if (act_ff == cle_pkg::ACT_INS_AFTER && last)
         eff_act = cle_pkg::ACT_APPEND;
      else if (act_ff == cle_pkg::ACT_DEL_CURSOR && cidx_ff == '0)
         eff_act = cle_pkg::ACT_DEL_FRONT;
      else if (act_ff == cle_pkg::ACT_DEL_CURSOR && last)
         eff_act = cle_pkg::ACT_DEL_BACK;
   end

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      cidx_in   = cidx_ff;
      cvalid_in = cvalid_ff;
      free_in   = free_ff;
      fresh_in  = fresh_ff;
      e_dw_en   = 1'b0;
      e_dw_addr = node_ff;
      e_nw_en   = 1'b0;
      e_nw_addr = node_ff;
      e_nw_data = NIL;
      e_pw_en   = 1'b0;
      e_pw_addr = node_ff;
      e_pw_data = NIL;
      e_n2_en   = 1'b0;
      e_n2_addr = cur_ff;
      e_n2_data = node_ff;
      e_p2_en   = 1'b0;
      e_p2_addr = cur_ff;
      e_p2_data = node_ff;
      if (status_ff == cle_pkg::ST_OK) begin
         // node taken for inserts
         if (act_ff == cle_pkg::ACT_PREPEND || act_ff == cle_pkg::ACT_APPEND ||
             act_ff == cle_pkg::ACT_INS_BEFORE || act_ff == cle_pkg::ACT_INS_AFTER) begin
            if (from_free_ff) free_in = nfree_ff;
            else fresh_in = fresh_ff + IW'(1);
         end
         case (eff_act)
            cle_pkg::ACT_MOVE_FRONT: begin
               if (!empty) begin
                  cur_in    = front_ff;
                  cidx_in   = '0;
                  cvalid_in = 1'b1;
               end
            end
            cle_pkg::ACT_MOVE_BACK: begin
               if (!empty) begin
                  cur_in    = back_ff;
                  cidx_in   = cnt_m1;
                  cvalid_in = 1'b1;
               end
            end
            cle_pkg::ACT_PREV: begin
               if (cvalid_ff) begin
                  if (cidx_ff == '0) begin
                     cvalid_in = 1'b0;
                     cur_in    = NIL;
                  end else begin
                     cur_in  = prd_ff;
                     cidx_in = cidx_ff - IW'(1);
                  end
               end
            end
            cle_pkg::ACT_NEXT: begin
               if (cvalid_ff) begin
                  if (last) begin
                     cvalid_in = 1'b0;
                     cur_in    = NIL;
                  end else begin
                     cur_in  = nrd_ff;
                     cidx_in = cidx_ff + IW'(1);
                  end
               end
            end
            cle_pkg::ACT_PREPEND: begin
               e_dw_en   = 1'b1;
               e_nw_en   = 1'b1;
               e_nw_data = front_ff;
               if (!empty) begin
                  e_pw_en   = 1'b1;
                  e_pw_addr = front_ff;
                  e_pw_data = node_ff;
               end else begin
                  back_in = node_ff;
               end
               front_in = node_ff;
               count_in = count_ff + IW'(1);
               if (cvalid_ff) cidx_in = cidx_ff + IW'(1);
            end
            cle_pkg::ACT_APPEND: begin
               e_dw_en   = 1'b1;
               e_pw_en   = 1'b1;
               e_pw_data = back_ff;
               if (!empty) begin
                  e_nw_en   = 1'b1;
                  e_nw_addr = back_ff;
                  e_nw_data = node_ff;
               end else begin
                  front_in = node_ff;
               end
               back_in  = node_ff;
               count_in = count_ff + IW'(1);
            end
            cle_pkg::ACT_INS_BEFORE: begin
               e_dw_en   = 1'b1;
               e_pw_en   = 1'b1;
               e_pw_data = prd_ff;
               e_nw_en   = 1'b1;
               e_nw_data = cur_ff;
               e_n2_en   = 1'b1;
               e_n2_addr = prd_ff;
               e_p2_en   = 1'b1;
               e_p2_addr = cur_ff;
               count_in  = count_ff + IW'(1);
               cidx_in   = cidx_ff + IW'(1);
            end
            cle_pkg::ACT_INS_AFTER: begin
               e_dw_en   = 1'b1;
               e_nw_en   = 1'b1;
               e_nw_data = nrd_ff;
               e_pw_en   = 1'b1;
               e_pw_data = cur_ff;
               e_p2_en   = 1'b1;
               e_p2_addr = nrd_ff;
               e_n2_en   = 1'b1;
               e_n2_addr = cur_ff;
               count_in  = count_ff + IW'(1);
            end
            cle_pkg::ACT_DEL_FRONT: begin
               if (cvalid_ff) begin
                  if (cidx_ff == '0) begin
                     cvalid_in = 1'b0;
                     cur_in    = NIL;
                  end else begin
                     cidx_in = cidx_ff - IW'(1);
                  end
               end
               if (count_ff > IW'(1)) begin
                  front_in = nrd_ff;
               end else begin
                  front_in = NIL;
                  back_in  = NIL;
               end
               e_nw_en   = 1'b1;
               e_nw_addr = front_ff;
               e_nw_data = free_ff;
               free_in   = front_ff;
               count_in  = cnt_m1;
            end
            cle_pkg::ACT_DEL_BACK: begin
               if (cvalid_ff && last) begin
                  cvalid_in = 1'b0;
                  cur_in    = NIL;
               end
               if (count_ff > IW'(1)) begin
                  back_in = prd_ff;
               end else begin
                  front_in = NIL;
                  back_in  = NIL;
               end
               e_nw_en   = 1'b1;
               e_nw_addr = back_ff;
               e_nw_data = free_ff;
               free_in   = back_ff;
               count_in  = cnt_m1;
            end
            cle_pkg::ACT_DEL_CURSOR: begin
               // interior node: unlink, then chain it onto the free list
               e_nw_en   = 1'b1;
               e_nw_addr = prd_ff;
               e_nw_data = nrd_ff;
               e_pw_en   = 1'b1;
               e_pw_addr = nrd_ff;
               e_pw_data = prd_ff;
               e_n2_en   = 1'b1;
               e_n2_addr = cur_ff;
               e_n2_data = free_ff;
               free_in   = cur_ff;
               cvalid_in = 1'b0;
               cur_in    = NIL;
               count_in  = cnt_m1;
            end
            cle_pkg::ACT_SET: begin
               e_dw_en   = 1'b1;
               e_dw_addr = cur_ff;
            end
            cle_pkg::ACT_CLEAR: begin
               // splice the whole list onto the free list
               if (!empty) begin
                  e_nw_en   = 1'b1;
                  e_nw_addr = back_ff;
                  e_nw_data = free_ff;
                  free_in   = front_ff;
               end
               front_in  = NIL;
               back_in   = NIL;
               cur_in    = NIL;
               count_in  = '0;
               cidx_in   = '0;
               cvalid_in = 1'b0;
            end
            default: begin
               cur_in = cur_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= NIL;
         back_ff   <= NIL;
         cur_ff    <= NIL;
         count_ff  <= '0;
         cidx_ff   <= '0;
         cvalid_ff <= 1'b0;
         free_ff   <= NIL;
         fresh_ff  <= '0;
         w2n_en_ff <= 1'b0;
         w2p_en_ff <= 1'b0;
      end else if (cmd.exec) begin
         front_ff  <= front_in;
         back_ff   <= back_in;
         cur_ff    <= cur_in;
         count_ff  <= count_in;
         cidx_ff   <= cidx_in;
         cvalid_ff <= cvalid_in;
         free_ff   <= free_in;
         fresh_ff  <= fresh_in;
         w2n_en_ff <= e_n2_en;
         w2p_en_ff <= e_p2_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         w2n_addr_ff <= e_n2_addr;
         w2n_data_ff <= e_n2_data;
         w2p_addr_ff <= e_p2_addr;
         w2p_data_ff <= e_p2_data;
      end
   end

   // --------------------------------------------------------- memory writes
   always_comb begin
      nw_en   = cmd.exec & e_nw_en;
      nw_addr = e_nw_addr;
      nw_data = e_nw_data;
      pw_en   = cmd.exec & e_pw_en;
      pw_addr = e_pw_addr;
      pw_data = e_pw_data;
      if (cmd.finish) begin
         nw_en   = w2n_en_ff;
         nw_addr = w2n_addr_ff;
         nw_data = w2n_data_ff;
         pw_en   = w2p_en_ff;
         pw_addr = w2p_addr_ff;
         pw_data = w2p_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (nw_en) next_mem[nw_addr[AW-1:0]] <= nw_data;
      if (pw_en) prev_mem[pw_addr[AW-1:0]] <= pw_data;
      if (cmd.exec && e_dw_en) begin
         data0_mem[e_dw_addr[AW-1:0]] <= val_ff;
         data1_mem[e_dw_addr[AW-1:0]] <= val_ff;
         data2_mem[e_dw_addr[AW-1:0]] <= val_ff;
      end
   end

   // value fetch, in the cycle after the value write
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         fdat_ff <= data0_mem[front_ff[AW-1:0]];
         bdat_ff <= data1_mem[back_ff[AW-1:0]];
         cdat_ff <= data2_mem[cur_ff[AW-1:0]];
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status          <= status_ff;
         rsp_list_length     <= cle_pkg::LENGTH_W'(count_ff);
         rsp_cursor_position <= cvalid_ff ? cle_pkg::POS_W'(cidx_ff) : '1;
         rsp_front_value     <= empty ? '0 : fdat_ff;
         rsp_back_value      <= empty ? '0 : bdat_ff;
         rsp_cursor_value    <= cvalid_ff ? cdat_ff : '0;
      end
   end

endmodule
